>>> rtl/rc5_ir_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// RC5 IR frame receiver assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef RC5_IR_FRAME_RECEIVER_DEFINES_SVH
`define RC5_IR_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, checked on the rising edge of clk outside reset
`define RC5IR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rc5ir: property violated");

// next-cycle implication
`define RC5IR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rc5ir: property violated");

`endif

>>> rtl/rc5ir_pkg.sv
// ----------------------------------------------------------------------------
// RC5 IR frame receiver package
// Register map, reset values and frame layout constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rc5ir_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned TickW    = 16;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned ShiftW   = 15;
  localparam int unsigned FrameW   = 14;
  localparam int unsigned CodeW    = 6;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_PULSE_MIN  = 3'd0;
  localparam logic [2:0] REG_PULSE_LONG = 3'd1;
  localparam logic [2:0] REG_PULSE_MAX  = 3'd2;
  localparam logic [2:0] REG_ADDR_LOW   = 3'd3;
  localparam logic [2:0] REG_ADDR_HIGH  = 3'd4;

  localparam logic [TickW-1:0] PULSE_MIN_RST  = 16'd14;
  localparam logic [TickW-1:0] PULSE_LONG_RST = 16'd28;
  localparam logic [TickW-1:0] PULSE_MAX_RST  = 16'd43;
  localparam logic [AddrW-1:0] ADDR_LOW_RST   = 5'd20;
  localparam logic [AddrW-1:0] ADDR_HIGH_RST  = 5'd31;

  // frame layout within the shift register
  localparam int unsigned BIT_OVER = 14;
  localparam int unsigned BIT_FULL = 13;
  localparam int unsigned ADDR_LSB = 6;

  // input request kinds
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_READ = 1'b1;

endpackage

`default_nettype wire

>>> rtl/rc5_ir_frame_receiver.sv
// ----------------------------------------------------------------------------
// RC5 IR frame receiver
// Result in the cycle after an accepted request; one request per cycle unless out_stall holds a pending result.
// Rate set by the single state update (counter, compares, shift) per request.
// Synchronous active-low reset clears state, registers to defaults, no frame.
// ----------------------------------------------------------------------------
`default_nettype none

module rc5_ir_frame_receiver
  import rc5ir_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // request channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_command,
  input  wire logic                in_pin_level,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_has_command,
  output logic [CodeW-1:0]         out_command_code,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0]      prdata,
  output logic                     pready
);

  logic [TickW-1:0]  pulse_min_r, pulse_long_r, pulse_max_r;
  logic [AddrW-1:0]  addr_low_r, addr_high_r;

  logic              last_level_r, last_level_nxt;
  logic [TickW-1:0]  pulse_cnt_r, pulse_cnt_nxt;
  logic [ShiftW-1:0] shift_r, shift_nxt;
  logic [FrameW-1:0] frame_r, frame_nxt;

  logic              out_valid_r;
  logic              out_has_r, out_has_nxt;
  logic [CodeW-1:0]  out_code_r, out_code_nxt;

  logic              in_acc;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[CfgAddrW-1:2];

  // result register frees itself when its content is taken
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_PULSE_MIN:  prdata = {{(CfgDataW-TickW){1'b0}}, pulse_min_r};
      REG_PULSE_LONG: prdata = {{(CfgDataW-TickW){1'b0}}, pulse_long_r};
      REG_PULSE_MAX:  prdata = {{(CfgDataW-TickW){1'b0}}, pulse_max_r};
      REG_ADDR_LOW:   prdata = {{(CfgDataW-AddrW){1'b0}}, addr_low_r};
      REG_ADDR_HIGH:  prdata = {{(CfgDataW-AddrW){1'b0}}, addr_high_r};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_min_r  <= PULSE_MIN_RST;
      pulse_long_r <= PULSE_LONG_RST;
      pulse_max_r  <= PULSE_MAX_RST;
      addr_low_r   <= ADDR_LOW_RST;
      addr_high_r  <= ADDR_HIGH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PULSE_MIN:  pulse_min_r  <= pwdata[TickW-1:0];
        REG_PULSE_LONG: pulse_long_r <= pwdata[TickW-1:0];
        REG_PULSE_MAX:  pulse_max_r  <= pwdata[TickW-1:0];
        REG_ADDR_LOW:   addr_low_r   <= pwdata[AddrW-1:0];
        REG_ADDR_HIGH:  addr_high_r  <= pwdata[AddrW-1:0];
        default: ;
      endcase
    end
  end

  // one request: counter, frame-end check, edge handling, read-and-clear
  always_comb begin
    logic [TickW-1:0]  cnt;
    logic [ShiftW-1:0] sr;
    logic [AddrW-1:0]  addr;

    last_level_nxt = last_level_r;
    pulse_cnt_nxt  = pulse_cnt_r;
    shift_nxt      = shift_r;
    frame_nxt      = frame_r;
    out_has_nxt    = 1'b0;
    out_code_nxt   = '0;

    cnt  = (pulse_cnt_r != {TickW{1'b1}}) ? pulse_cnt_r + 16'd1 : pulse_cnt_r;
    sr   = shift_r;
    addr = shift_r[ADDR_LSB +: AddrW];

    if (in_command == CMD_TICK) begin
      if (cnt > pulse_max_r) begin
        if (!sr[BIT_OVER] && sr[BIT_FULL] && addr >= addr_low_r && addr <= addr_high_r)
          frame_nxt = sr[FrameW-1:0];
        sr = '0;
      end

      if (in_pin_level != last_level_r) begin
        last_level_nxt = in_pin_level;
        if (cnt < pulse_min_r)
          sr = '0;
        if (sr == '0 || cnt > pulse_long_r) begin
          // a full register stops shifting but still takes the new bit
          if (!sr[BIT_OVER])
            sr = {sr[ShiftW-2:0], 1'b0};
          if (!in_pin_level)
            sr[0] = 1'b1;
          cnt = '0;
        end
      end

      pulse_cnt_nxt = cnt;
      shift_nxt     = sr;
    end else if (frame_r != '0) begin
      out_has_nxt  = 1'b1;
      out_code_nxt = frame_r[CodeW-1:0];
      frame_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b0;
      pulse_cnt_r  <= '0;
      shift_r      <= '0;
      frame_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        last_level_r <= last_level_nxt;
        pulse_cnt_r  <= pulse_cnt_nxt;
        shift_r      <= shift_nxt;
        frame_r      <= frame_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_has_r  <= out_has_nxt;
      out_code_r <= out_code_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_has_command  = out_has_r;
  assign out_command_code = out_code_r;

endmodule

`default_nettype wire

>>> rtl/rc5ir_checker.sv
// ----------------------------------------------------------------------------
// RC5 IR frame receiver port checker
// Watches the top-level ports and flags result sequencing errors.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rc5_ir_frame_receiver_defines.svh"

module rc5ir_checker
  import rc5ir_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             in_command,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic             out_has_command,
  input wire logic [CodeW-1:0] out_command_code
);

  logic in_take;
  logic rd_take;

  assign in_take = in_valid && !in_stall;
  assign rd_take = in_take && (in_command == CMD_READ);

  // a stalled result holds
  `RC5IR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_has_command) && $stable(out_command_code))

  // a tick request yields an empty result in the next cycle
  `RC5IR_ASSERT_NEXT(a_tick_result, in_take && (in_command == CMD_TICK),
    out_valid && !out_has_command && (out_command_code == '0))

  `RC5IR_ASSERT_NOW(a_empty_code, out_valid && !out_has_command,
    out_command_code == '0)

  // back-to-back reads: the second finds the latch cleared
  `RC5IR_ASSERT_NEXT(a_read_clears, rd_take && $past(rd_take),
    !out_has_command)

endmodule

bind rc5_ir_frame_receiver rc5ir_checker u_rc5ir_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_command       (in_command),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_has_command  (out_has_command),
  .out_command_code (out_command_code)
);

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// RC5 IR frame receiver testbench
// Feeds pin samples and read requests through the valid/stall request
// channel. Most of the stimulus is Manchester-coded frames at several pulse
// timings, with glitches, odd frame lengths and noise. The timing and
// address-window registers are reprogrammed between phases over the APB
// port. A local decoder predicts every reply, and each reply is checked
// field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import rc5ir_pkg::*;

  typedef struct packed {
    logic command;
    logic pin;
  } ir_request_t;

  typedef struct packed {
    logic             has_command;
    logic [CodeW-1:0] code;
  } ir_reply_t;

  localparam int unsigned PHASE_ITEMS = 70;
  localparam int unsigned NUM_PHASES  = 14;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = CMD_TICK;
  logic in_pin_level = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_has_command;
  logic [CodeW-1:0] out_command_code;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic pready;

  // decoder state and register copies
  logic              edge_level  = 1'b0;
  logic [TickW-1:0]  pulse_count = '0;
  logic [ShiftW-1:0] shift_reg   = '0;
  logic [FrameW-1:0] held_frame  = '0;
  logic [TickW-1:0]  min_ticks   = PULSE_MIN_RST;
  logic [TickW-1:0]  long_ticks  = PULSE_LONG_RST;
  logic [TickW-1:0]  max_ticks   = PULSE_MAX_RST;
  logic [AddrW-1:0]  addr_lo     = ADDR_LOW_RST;
  logic [AddrW-1:0]  addr_hi     = ADDR_HIGH_RST;

  ir_request_t sample_queue[$];
  ir_reply_t   expected_replies[$];

  int unsigned requests_queued = 0;
  int unsigned replies_seen = 0;
  int unsigned mismatches = 0;
  logic req_taken = 1'b0;
  logic steady_flow = 1'b0;
  logic backlog_wanted = 1'b0;
  logic backlog_done = 1'b0;
  int unsigned backlog_cycles = 0;

  rc5_ir_frame_receiver DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_pin_level     (in_pin_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_has_command  (out_has_command),
    .out_command_code (out_command_code),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic ir_reply_t decode_request(input ir_request_t r);
    ir_reply_t         rep;
    logic [ShiftW-1:0] sr;
    logic [AddrW-1:0]  frame_addr;
    rep = '0;
    if (r.command == CMD_READ) begin
      if (held_frame != '0) begin
        rep.has_command = 1'b1;
        rep.code = held_frame[CodeW-1:0];
        held_frame = '0;
      end
    end else begin
      sr = shift_reg;
      if (pulse_count != '1) pulse_count = pulse_count + 1'b1;
      // idle gap: judge what has been collected, then start afresh
      if (pulse_count > max_ticks) begin
        if (!sr[BIT_OVER] && sr[BIT_FULL]) begin
          frame_addr = sr[ADDR_LSB +: AddrW];
          if (frame_addr >= addr_lo && frame_addr <= addr_hi) held_frame = sr[FrameW-1:0];
        end
        sr = '0;
      end
      if (r.pin != edge_level) begin
        edge_level = r.pin;
        if (pulse_count < min_ticks) sr = '0;
        if (sr == '0 || pulse_count > long_ticks) begin
          if (!sr[BIT_OVER]) sr = sr << 1;
          if (!edge_level) sr[0] = 1'b1;
          pulse_count = '0;
        end
      end
      shift_reg = sr;
    end
    return rep;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    // keep the log readable if everything goes wrong
    if (mismatches < 50)
      $display("reply %0d: %s got %0d expected %0d", replies_seen, what, got, want);
    mismatches++;
  endtask

  // request driver
  always @(negedge clk) begin : feed
    ir_request_t next_req;
    if (rst_n && (!in_valid || req_taken)) begin
      if (sample_queue.size() != 0 &&
          (steady_flow || backlog_cycles != 0 || $urandom_range(0, 99) >= 36)) begin
        next_req = sample_queue.pop_front();
        in_valid <= 1'b1;
        in_command <= next_req.command;
        in_pin_level <= next_req.pin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // reply side stall, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (backlog_cycles != 0) begin
      out_stall <= 1'b1;
      backlog_cycles <= backlog_cycles - 1;
    end else if (backlog_wanted && !backlog_done) begin
      out_stall <= 1'b1;
      backlog_cycles <= 60;
      backlog_done <= 1'b1;
    end else begin
      out_stall <= !steady_flow && ($urandom_range(0, 99) < 36);
    end
  end

  // monitor: replies checked before the request of this edge is predicted
  always @(posedge clk) begin : watch
    ir_reply_t want;
    req_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with no request outstanding", 1, 0);
        end else begin
          want = expected_replies.pop_front();
          if (out_has_command !== want.has_command)
            report_mismatch("has_command", out_has_command, want.has_command);
          if (out_command_code !== want.code)
            report_mismatch("command_code", out_command_code, want.code);
        end
        replies_seen++;
      end
      if (in_valid && !in_stall) begin
        req_taken = 1'b1;
        expected_replies.push_back(decode_request('{in_command, in_pin_level}));
      end
    end
  end

  task automatic queue_request(input logic command, input logic pin);
    sample_queue.push_back('{command, pin});
    requests_queued++;
  endtask

  task automatic drain();
    while (sample_queue.size() != 0 || in_valid || expected_replies.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input int unsigned value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CfgAddrW'({idx, 2'b00});
    pwdata <= CfgDataW'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_PULSE_MIN:  min_ticks = TickW'(value);
      REG_PULSE_LONG: long_ticks = TickW'(value);
      REG_PULSE_MAX:  max_ticks = TickW'(value);
      REG_ADDR_LOW:   addr_lo = AddrW'(value);
      REG_ADDR_HIGH:  addr_hi = AddrW'(value);
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_receiver(input int unsigned pmin, input int unsigned plong,
                                  input int unsigned pmax, input int unsigned lo,
                                  input int unsigned hi);
    drain();
    cfg_write(REG_PULSE_MIN, pmin);
    cfg_write(REG_PULSE_LONG, plong);
    cfg_write(REG_PULSE_MAX, pmax);
    cfg_write(REG_ADDR_LOW, lo);
    cfg_write(REG_ADDR_HIGH, hi);
  endtask

  // Manchester frame: a 1 bit is high then low, the mid-bit edge carries it
  task automatic queue_frame(input int unsigned half, input bit broken);
    int unsigned nbits, tail, glitch_at, n;
    int          i, k;
    logic [15:0] bits;
    logic        lvl;
    nbits = broken ? $urandom_range(10, 16) : 14;
    bits = 16'($urandom);
    if (!broken || $urandom_range(0, 1)) bits[nbits-1] = 1'b1;
    if (nbits == 14 && $urandom_range(0, 1))
      bits[ADDR_LSB +: AddrW] = AddrW'($urandom_range(addr_hi, addr_lo));
    glitch_at = broken ? $urandom_range(0, nbits * 2 * half - 1) : 32'hFFFF_FFFF;
    n = 0;
    lvl = 1'b0;
    for (i = nbits - 1; i >= 0; i--) begin
      for (k = 0; k < 2 * half; k++) begin
        lvl = bits[i] ^ (k >= half);
        queue_request(CMD_TICK, lvl ^ (n == glitch_at));
        n++;
        if ($urandom_range(0, 39) == 0) queue_request(CMD_READ, 1'($urandom));
      end
    end
    tail = (max_ticks < 8) ? max_ticks + 1 + $urandom_range(0, 3) : $urandom_range(4, 12);
    repeat (tail) queue_request(CMD_TICK, lvl);
  endtask

  initial begin : stimulus
    int unsigned phase, phase_start, half, pick, lo, hi, burst;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty reads with both pin levels, then two early edges
    queue_request(CMD_READ, 1'b0);
    queue_request(CMD_READ, 1'b1);
    queue_request(CMD_TICK, 1'b1);
    queue_request(CMD_TICK, 1'b0);
    // every edge is a bit edge, the second idle tick ends the frame
    program_receiver(0, 0, 1, 0, 31);
    queue_request(CMD_TICK, 1'b0);
    queue_request(CMD_TICK, 1'b0);
    for (int t = 0; t < 15; t++) queue_request(CMD_TICK, ~t[0]);
    queue_request(CMD_TICK, 1'b1);
    queue_request(CMD_TICK, 1'b1);
    queue_request(CMD_READ, 1'b0);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      pick = $urandom_range(0, 9);
      half = (pick < 6) ? 1 : ((pick < 9) ? 2 : 3);
      case ($urandom_range(0, 9))
        0, 1: begin
          lo = 0;
          hi = 31;
        end
        2: begin
          lo = $urandom_range(1, 31);
          hi = $urandom_range(0, lo - 1);
        end
        3: begin
          lo = $urandom_range(0, 31);
          hi = lo;
        end
        default: begin
          lo = $urandom_range(0, 31);
          hi = $urandom_range(lo, 31);
        end
      endcase
      case (phase)
        0: program_receiver(0, 0, 0, 31, 31);
        1: program_receiver(16'hFFFF, 16'hFFFF, 16'hFFFF, 31, 0);
        default: program_receiver($urandom_range(0, half), $urandom_range(half, 2 * half - 1),
                                  $urandom_range(2 * half, 2 * half + 3), lo, hi);
      endcase
      steady_flow = (phase == 5);
      if (phase == 8) backlog_wanted = 1'b1;
      phase_start = requests_queued;
      while (requests_queued - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          queue_frame(half, 1'b0);
          if ($urandom_range(0, 9) < 6) queue_request(CMD_READ, 1'($urandom));
        end else if (pick < 85) begin
          queue_frame($urandom_range(1, 4), 1'b1);
          if ($urandom_range(0, 1)) queue_request(CMD_READ, 1'($urandom));
        end else begin
          burst = $urandom_range(4, 12);
          repeat (burst)
            queue_request(($urandom_range(0, 3) == 0) ? CMD_READ : CMD_TICK, 1'($urandom));
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
